FILE: rtl/spwm_pkg.sv
package spwm_pkg;

    localparam int TICK_W     = 12;
    localparam int US_W       = 16;
    localparam int FREQ_W     = 11;
    localparam int CHAN_W     = 4;
    localparam int GRP_W      = 2;
    localparam int REGADDR_W  = 7;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;
    localparam int PROD_W     = US_W + FREQ_W;

    typedef logic [TICK_W-1:0]     tick_t;
    typedef logic [US_W-1:0]       us_t;
    typedef logic [FREQ_W-1:0]     freq_t;
    typedef logic [CHAN_W-1:0]     chan_t;
    typedef logic [GRP_W-1:0]      grp_t;
    typedef logic [REGADDR_W-1:0]  regaddr_t;
    typedef logic [CFG_IDX_W-1:0]  cfgidx_t;
    typedef logic [CFG_DATA_W-1:0] cfgdata_t;
    typedef logic [PROD_W-1:0]     prod_t;

    localparam int SERVO_COUNT_DEF = 16;
    localparam int GROUP_COUNT_DEF = 4;
    localparam int MAX_RESULTS     = 4;
    localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

    localparam int OFF_BASE = 8;

    localparam tick_t THR_RESET  = tick_t'(5);
    localparam freq_t FREQ_RESET = freq_t'(60);
    localparam tick_t TICK_MAX   = tick_t'(4095);

    // ticks = floor(p * 4096 / 1e6) = floor((p << 6) / 15625) for p below 1e6
    localparam prod_t SAT_LIMIT   = prod_t'(1000000);
    localparam int    DIV_SHIFT   = 6;
    localparam int    X_W         = 26;
    localparam int    DIV_D       = 15625;
    localparam int    RECIP_SHIFT = 26;
    localparam int    RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'((2 ** RECIP_SHIFT) / DIV_D);

    localparam cfgidx_t REG_SYNC_THRESHOLD = cfgidx_t'(0);
    localparam cfgidx_t REG_PWM_FREQUENCY  = cfgidx_t'(1);

    localparam logic FUNC_SET  = 1'b0;
    localparam logic FUNC_SYNC = 1'b1;

    typedef struct packed {
        logic  valid;
        tick_t ticks;
    } conv_t;

endpackage

FILE: rtl/spwm_ram.sv
module spwm_ram #(
    parameter int WIDTH = spwm_pkg::TICK_W,
    parameter int DEPTH = spwm_pkg::SERVO_COUNT_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/spwm_conv.sv
module spwm_conv (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  spwm_pkg::us_t   pulse_us,
    input  spwm_pkg::freq_t freq,
    output spwm_pkg::conv_t conv_out
);

    localparam int X_W = spwm_pkg::X_W;
    localparam int QM_W = X_W + spwm_pkg::RECIP_W;
    localparam int R_W = X_W + 1;

    logic                    s1_valid_reg;
    spwm_pkg::prod_t         p_reg;
    logic                    s2_valid_reg;
    logic                    sat_reg;
    logic [X_W-1:0]          x_reg;
    spwm_pkg::tick_t         q0_reg;

    logic [X_W-1:0]          x_next;
    logic [QM_W-1:0]         qm;
    logic [R_W-1:0]          q0d;
    logic [R_W-1:0]          rem;
    spwm_pkg::tick_t         q;

    // stage 1: microseconds times frequency
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= spwm_pkg::prod_t'(pulse_us) * spwm_pkg::prod_t'(freq);
        sat_reg <= p_reg >= spwm_pkg::SAT_LIMIT;
        x_reg   <= x_next;
        q0_reg  <= qm[spwm_pkg::RECIP_SHIFT +: spwm_pkg::TICK_W];
    end

    // stage 2: reciprocal estimate, at most one below the true quotient
    assign x_next = {p_reg[X_W-spwm_pkg::DIV_SHIFT-1:0], {spwm_pkg::DIV_SHIFT{1'b0}}};
    assign qm = QM_W'(x_next) * QM_W'(spwm_pkg::RECIP_M);

    // stage 3: one correction step, then saturation
    assign q0d = R_W'(q0_reg) * R_W'(spwm_pkg::DIV_D);
    assign rem = R_W'(x_reg) - q0d;
    assign q   = (rem >= R_W'(spwm_pkg::DIV_D)) ? q0_reg + spwm_pkg::tick_t'(1) : q0_reg;

    assign conv_out.valid = s2_valid_reg;
    assign conv_out.ticks = sat_reg ? spwm_pkg::TICK_MAX : q;

endmodule

FILE: rtl/servo_pwm_deadband_sync_core.sv
// set item: accepted, then busy while the tick conversion pipeline runs
// sync item: busy while it makes one table read per
// member through the two tick memories, stopping early after the fourth write
// each result is a one-cycle strobe pulse, at most one per cycle, the last one in the
// first cycle with busy low; results cannot be stalled; one item at a time
// rst_n clears control state and valid bits, sets config defaults; no clearing pass
module servo_pwm_deadband_sync_core #(
    parameter int SERVO_COUNT = spwm_pkg::SERVO_COUNT_DEF,
    parameter int GROUP_COUNT = spwm_pkg::GROUP_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 func,
    input  spwm_pkg::chan_t      servo_index,
    input  spwm_pkg::us_t        pulse_us,
    input  spwm_pkg::grp_t       group_index,
    output logic                 strobe,
    output spwm_pkg::chan_t      channel,
    output spwm_pkg::regaddr_t   register_address,
    output spwm_pkg::tick_t      off_ticks,
    output logic                 last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  spwm_pkg::cfgidx_t    cfg_index,
    input  spwm_pkg::cfgdata_t   cfg_data
);

    localparam int AW = $clog2(SERVO_COUNT);
    localparam int IW = $clog2(SERVO_COUNT + GROUP_COUNT);
    localparam int CW = spwm_pkg::CNT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CONV  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]             state_reg, state_next;
    spwm_pkg::tick_t        thr_reg;
    spwm_pkg::freq_t        freq_reg;

    logic [AW-1:0]          set_addr_reg;
    logic                   set_ok_reg;

    logic [IW-1:0]          idx_reg, idx_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic [AW-1:0]          rd_idx_reg, rd_idx_next;
    logic                   req_vld_rd_reg, wr_vld_rd_reg;
    logic                   pend_valid_reg, pend_valid_next;
    logic [AW-1:0]          pend_idx_reg, pend_idx_next;
    spwm_pkg::tick_t        pend_ticks_reg, pend_ticks_next;
    logic [CW-1:0]          count_reg, count_next;

    logic [SERVO_COUNT-1:0] req_vld_reg, wr_vld_reg;

    logic                   strobe_reg;
    spwm_pkg::chan_t        channel_reg;
    spwm_pkg::regaddr_t     regaddr_reg;
    spwm_pkg::tick_t        ticks_reg;
    logic                   last_reg;

    logic                   accept;
    spwm_pkg::conv_t        conv_out;
    logic                   issue;
    logic [AW-1:0]          rd_addr;
    spwm_pkg::tick_t        req_q, wr_q, r_val, w_val, diff;
    logic                   hit;
    logic                   req_we, wr_we;
    logic                   emit;
    logic [AW-1:0]          emit_idx;
    spwm_pkg::tick_t        emit_ticks;
    logic                   emit_last;

    assign busy      = state_reg != ST_IDLE;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= spwm_pkg::THR_RESET;
            freq_reg <= spwm_pkg::FREQ_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                spwm_pkg::REG_SYNC_THRESHOLD: thr_reg  <= cfg_data;
                spwm_pkg::REG_PWM_FREQUENCY:  freq_reg <= cfg_data[spwm_pkg::FREQ_W-1:0];
                default: ;
            endcase
        end
    end

    spwm_conv u_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept && func == spwm_pkg::FUNC_SET),
        .pulse_us (pulse_us),
        .freq     (freq_reg),
        .conv_out (conv_out)
    );

    assign req_we = conv_out.valid && set_ok_reg;

    spwm_ram #(
        .WIDTH (spwm_pkg::TICK_W),
        .DEPTH (SERVO_COUNT)
    ) u_req_ram (
        .clk   (clk),
        .we    (req_we),
        .waddr (set_addr_reg),
        .wdata (conv_out.ticks),
        .re    (issue),
        .raddr (rd_addr),
        .rdata (req_q)
    );

    spwm_ram #(
        .WIDTH (spwm_pkg::TICK_W),
        .DEPTH (SERVO_COUNT)
    ) u_wr_ram (
        .clk   (clk),
        .we    (wr_we),
        .waddr (rd_idx_reg),
        .wdata (r_val),
        .re    (issue),
        .raddr (rd_addr),
        .rdata (wr_q)
    );

    // entries never written read as zero
    assign r_val = req_vld_rd_reg ? req_q : '0;
    assign w_val = wr_vld_rd_reg ? wr_q : '0;
    assign diff  = (r_val > w_val) ? r_val - w_val : w_val - r_val;
    assign hit   = state_reg == ST_SCAN && rd_valid_reg && diff > thr_reg;
    assign wr_we = hit;

    assign issue   = state_reg == ST_SCAN && idx_reg < IW'(SERVO_COUNT);
    assign rd_addr = idx_reg[AW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        rd_valid_next   = 1'b0;
        rd_idx_next     = rd_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_ticks_next = pend_ticks_reg;
        count_next      = count_reg;
        emit            = 1'b0;
        emit_idx        = pend_idx_reg;
        emit_ticks      = pend_ticks_reg;
        emit_last       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == spwm_pkg::FUNC_SET)
                    begin
                        state_next = ST_CONV;
                    end
                    else if (int'(group_index) < GROUP_COUNT)
                    begin
                        state_next      = ST_SCAN;
                        idx_next        = IW'(group_index);
                        pend_valid_next = 1'b0;
                        count_next      = '0;
                    end
                end
            end
            ST_CONV:
            begin
                if (conv_out.valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    rd_valid_next = 1'b1;
                    rd_idx_next   = rd_addr;
                    idx_next      = idx_reg + IW'(GROUP_COUNT);
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
                if (hit)
                begin
                    // the held write goes out once a later one proves it is not last
                    emit            = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    pend_idx_next   = rd_idx_reg;
                    pend_ticks_next = r_val;
                    count_next      = count_reg + CW'(1);
                    if (count_next == CW'(spwm_pkg::MAX_RESULTS))
                    begin
                        state_next    = ST_FLUSH;
                        rd_valid_next = 1'b0;
                    end
                end
            end
            ST_FLUSH:
            begin
                emit            = pend_valid_reg;
                emit_last       = 1'b1;
                pend_valid_next = 1'b0;
                count_next      = '0;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            req_vld_reg    <= '0;
            wr_vld_reg     <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_valid_reg   <= rd_valid_next;
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
            strobe_reg     <= emit;
            if (req_we)
            begin
                req_vld_reg[set_addr_reg] <= 1'b1;
            end
            if (wr_we)
            begin
                wr_vld_reg[rd_idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        rd_idx_reg     <= rd_idx_next;
        pend_idx_reg   <= pend_idx_next;
        pend_ticks_reg <= pend_ticks_next;
        if (issue)
        begin
            req_vld_rd_reg <= req_vld_reg[rd_addr];
            wr_vld_rd_reg  <= wr_vld_reg[rd_addr];
        end
        if (accept)
        begin
            set_addr_reg <= AW'(servo_index);
            set_ok_reg   <= int'(servo_index) < SERVO_COUNT;
        end
        if (emit)
        begin
            channel_reg <= spwm_pkg::chan_t'(emit_idx);
            regaddr_reg <= spwm_pkg::regaddr_t'(spwm_pkg::OFF_BASE + 4 * int'(emit_idx));
            ticks_reg   <= emit_ticks;
            last_reg    <= emit_last;
        end
    end

    assign strobe           = strobe_reg;
    assign channel          = channel_reg;
    assign register_address = regaddr_reg;
    assign off_ticks        = ticks_reg;
    assign last             = last_reg;

    a_strobe_from_sync: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> ($past(state_reg) == ST_SCAN || $past(state_reg) == ST_FLUSH))
        else $error("result outside a sync");

    a_conv_only_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        conv_out.valid |-> state_reg == ST_CONV)
        else $error("conversion result outside a set item");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(spwm_pkg::MAX_RESULTS))
        else $error("too many writes in one sync");

    // a new item may be taken in the cycle that carries the last write
    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && last_reg) |-> state_reg == ST_IDLE ##1 !strobe_reg)
        else $error("result after last");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !rd_valid_reg && !pend_valid_reg)
        else $error("sync state left behind");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import spwm_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 6;
    localparam int SERVOS         = SERVO_COUNT_DEF;
    localparam int GROUPS         = GROUP_COUNT_DEF;
    localparam int TICK_STEPS     = 4096;
    localparam int US_PER_SECOND  = 1000000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SEGMENTS       = 9;
    localparam int SEGMENT_ITEMS  = 31;

    localparam cfgidx_t SPARE_FIRST = REG_PWM_FREQUENCY + cfgidx_t'(1);
    localparam cfgidx_t SPARE_LAST  = '1;

    typedef struct {
        chan_t    channel;
        regaddr_t reg_addr;
        tick_t    ticks;
        logic     last;
    } servo_write_t;

    class servo_write_model;
        tick_t        threshold;
        freq_t        freq_hz;
        tick_t        requested[SERVOS];
        tick_t        written[SERVOS];
        servo_write_t pending_writes[$];
        int           errors;

        function new();
            threshold = THR_RESET;
            freq_hz   = FREQ_RESET;
            errors    = 0;
            foreach (requested[i])
            begin
                requested[i] = '0;
                written[i]   = '0;
            end
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        function int pending();
            return pending_writes.size();
        endfunction

        function void apply_config(cfgidx_t idx, cfgdata_t data);
            if (idx == REG_SYNC_THRESHOLD)
                threshold = tick_t'(data);
            else if (idx == REG_PWM_FREQUENCY)
                freq_hz = freq_t'(data);
        endfunction

        function tick_t us_to_ticks(us_t us);
            longint unsigned t;
            t = (longint'(us) * longint'(freq_hz) * longint'(TICK_STEPS))
                / longint'(US_PER_SECOND);
            return (t > longint'(TICK_MAX)) ? TICK_MAX : tick_t'(t);
        endfunction

        function void note_item(logic f, chan_t idx, us_t us, grp_t grp);
            servo_write_t batch[$];
            servo_write_t w;
            int           diff;
            if (f == FUNC_SET)
            begin
                if (int'(idx) < SERVOS)
                    requested[idx] = us_to_ticks(us);
                return;
            end
            for (int i = 0; i < SERVOS; i++)
            begin
                if (batch.size() < MAX_RESULTS && (i % GROUPS) == int'(grp))
                begin
                    diff = int'(requested[i]) - int'(written[i]);
                    if (diff < 0)
                        diff = -diff;
                    if (diff > int'(threshold))
                    begin
                        w.channel  = chan_t'(i);
                        w.reg_addr = regaddr_t'(OFF_BASE + 4 * i);
                        w.ticks    = requested[i];
                        w.last     = 1'b0;
                        batch.push_back(w);
                        written[i] = requested[i];
                    end
                end
            end
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i])
                pending_writes.push_back(batch[i]);
        endfunction

        task check_write(chan_t ch, regaddr_t addr, tick_t ticks, logic lst);
            servo_write_t e;
            if (pending_writes.size() == 0)
            begin
                report($sformatf("unexpected write ch %0d addr 0x%0h ticks %0d last %0b",
                                 ch, addr, ticks, lst));
                return;
            end
            e = pending_writes.pop_front();
            if (ch !== e.channel || addr !== e.reg_addr || ticks !== e.ticks ||
                lst !== e.last)
                report($sformatf({"write got ch %0d addr 0x%0h ticks %0d last %0b, ",
                                  "exp ch %0d addr 0x%0h ticks %0d last %0b"},
                                 ch, addr, ticks, lst,
                                 e.channel, e.reg_addr, e.ticks, e.last));
        endtask

        task finish_check();
            if (pending_writes.size() != 0)
                report($sformatf("%0d expected writes never appeared",
                                 pending_writes.size()));
        endtask
    endclass

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    logic     busy;
    logic     func;
    chan_t    servo_index;
    us_t      pulse_us;
    grp_t     group_index;
    logic     strobe;
    chan_t    channel;
    regaddr_t register_address;
    tick_t    off_ticks;
    logic     last;
    logic     cfg_valid;
    logic     cfg_ready;
    cfgidx_t  cfg_index;
    cfgdata_t cfg_data;

    servo_write_model model = new();
    int idle_pct = 25;
    int quiet_cycles = 0;

    servo_pwm_deadband_sync_core DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .func             (func),
        .servo_index      (servo_index),
        .pulse_us         (pulse_us),
        .group_index      (group_index),
        .strobe           (strobe),
        .channel          (channel),
        .register_address (register_address),
        .off_ticks        (off_ticks),
        .last             (last),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe)
                model.check_write(channel, register_address, off_ticks, last);
            if (start && !busy)
                model.note_item(func, servo_index, pulse_us, group_index);
            if (cfg_valid && cfg_ready)
                model.apply_config(cfg_index, cfg_data);
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || strobe || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_item(logic f, chan_t idx, us_t us, grp_t grp);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        func        <= f;
        servo_index <= idx;
        pulse_us    <= us;
        group_index <= grp;
        do @(posedge clk); while (busy);
    endtask

    task automatic set_pulse(chan_t idx, us_t us);
        send_item(FUNC_SET, idx, us, grp_t'($urandom));
    endtask

    task automatic sync_group(grp_t grp);
        send_item(FUNC_SYNC, chan_t'($urandom), us_t'($urandom), grp);
    endtask

    // hold off until every write is out and the block has gone quiet
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (model.pending() != 0 || busy);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_beat(cfgidx_t idx, cfgdata_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic write_config(cfgdata_t thr, cfgdata_t freq);
        drain();
        // unused index must leave both registers alone
        cfg_beat(cfgidx_t'($urandom_range(SPARE_FIRST, SPARE_LAST)), cfgdata_t'($urandom));
        cfg_beat(REG_SYNC_THRESHOLD, thr);
        cfg_beat(REG_PWM_FREQUENCY, freq);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        int   pick;
        us_t  us;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            us = us_t'($urandom_range(400, 2600));
        else if (pick < 85)
            us = us_t'($urandom_range(0, 40));
        else
            us = us_t'($urandom);
        if ($urandom_range(0, 99) < 65)
            set_pulse(chan_t'($urandom), us);
        else
            sync_group(grp_t'($urandom));
    endtask

    initial
    begin
        cfgdata_t thr;
        cfgdata_t freq;
        rst_n       = 1'b0;
        start       <= 1'b0;
        func        <= FUNC_SET;
        servo_index <= '0;
        pulse_us    <= '0;
        group_index <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_SYNC_THRESHOLD;
        cfg_data    <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under reset settings
        sync_group(grp_t'(0));
        set_pulse(chan_t'(0), us_t'(16'hFFFF));
        set_pulse(chan_t'(4), us_t'(0));
        set_pulse(chan_t'(8), us_t'(1500));
        set_pulse(chan_t'(12), us_t'(1));
        sync_group(grp_t'(0));
        set_pulse(chan_t'(8), us_t'(1520));
        sync_group(grp_t'(0));
        set_pulse(chan_t'(8), us_t'(1525));
        sync_group(grp_t'(0));
        set_pulse(chan_t'(1), us_t'(16'hFFFF));
        set_pulse(chan_t'(5), us_t'(2000));
        set_pulse(chan_t'(9), us_t'(1000));
        set_pulse(chan_t'(13), us_t'(3000));
        sync_group(grp_t'(1));
        sync_group(grp_t'(1));
        set_pulse(chan_t'(2), us_t'(800));
        set_pulse(chan_t'(3), us_t'(2200));
        set_pulse(chan_t'(15), us_t'(16'h8000));
        set_pulse(chan_t'(15), us_t'(16'h7FFF));
        sync_group(grp_t'(2));
        sync_group(grp_t'(3));
        set_pulse(chan_t'(14), us_t'(600));
        sync_group(grp_t'(2));

        for (int s = 0; s < SEGMENTS; s++)
        begin
            idle_pct = (s < 3) ? 25 : (s < 6) ? 72 : 0;
            case (s)
                0:
                begin
                    thr  = '0;
                    freq = cfgdata_t'(1526);
                end
                1:
                begin
                    thr  = '1;
                    freq = cfgdata_t'(24);
                end
                2:
                begin
                    thr  = cfgdata_t'($urandom_range(0, 20));
                    freq = '0;
                end
                3:
                begin
                    thr  = cfgdata_t'(3);
                    freq = '1;
                end
                default:
                begin
                    thr  = ($urandom_range(0, 9) == 0) ? cfgdata_t'($urandom)
                                                       : cfgdata_t'($urandom_range(0, 40));
                    freq = cfgdata_t'($urandom_range(24, 1526));
                end
            endcase
            write_config(thr, freq);
            for (int n = 0; n < SEGMENT_ITEMS; n++)
            begin
                if (s == 4 && n == SEGMENT_ITEMS / 2)
                    drain();
                random_item();
            end
        end

        drain();
        model.finish_check();
        if (model.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
